@@ hdl/fdh_pkg.sv @@
// Shared types, constants and decision functions for the fan duty hysteresis controller.
package fdh_pkg;

  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 48;
  localparam int unsigned USER_W = 2;

  // Speed = SPEED_NUM / tach count, one quotient bit per cycle.
  localparam int unsigned SPEED_W = 22;
  localparam logic [SPEED_W-1:0] SPEED_NUM = 22'd2156220;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'(SPEED_W - 1);

  // Sequencer steps that carry the duty decision alongside the division.
  localparam logic [STEP_W-1:0] STEP_MEAS   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_TARGET = 5'd1;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 5'd2;

  // floor(y / 100) for y <= 25500 as (y * RECIP_100) >> 19.
  localparam logic [12:0] RECIP_100 = 13'd5243;

  localparam logic [7:0] NO_DUTY = 8'hFF;

  localparam int unsigned NUM_STEPS = 7;
  localparam logic [6:0] DUTY_STEPS [NUM_STEPS] = '{
    7'd0, 7'd16, 7'd30, 7'd40, 7'd65, 7'd90, 7'd100
  };

  // Temperature thresholds of the ladder.
  localparam logic [7:0] T_UP_65   = 8'd85;
  localparam logic [7:0] T_UP_40   = 8'd75;
  localparam logic [7:0] T_UP_30   = 8'd65;
  localparam logic [7:0] T_UP_17   = 8'd55;
  localparam logic [7:0] T_OFF     = 8'd50;
  localparam logic [7:0] T_DOWN_17 = 8'd60;
  localparam logic [7:0] T_DOWN_30 = 8'd70;
  localparam logic [7:0] T_DOWN_40 = 8'd80;
  localparam logic [7:0] T_DOWN_65 = 8'd85;

  localparam logic [6:0] D_17 = 7'd17;
  localparam logic [6:0] D_30 = 7'd30;
  localparam logic [6:0] D_40 = 7'd40;
  localparam logic [6:0] D_65 = 7'd65;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  // Snap to the first duty step within +-1; the zero step needs an exact zero.
  function automatic logic [6:0] snap_duty(input logic [6:0] d);
    logic [6:0] res;
    logic       hit;
    logic [7:0] s8;
    res = d;
    hit = 1'b0;
    for (int i = 0; i < NUM_STEPS; i++) begin
      s8 = {1'b0, DUTY_STEPS[i]};
      if (!hit) begin
        if (DUTY_STEPS[i] == 7'd0) begin
          if (d == 7'd0) begin
            res = 7'd0;
            hit = 1'b1;
          end
        end else if ((({1'b0, d} + 8'd1) >= s8) && ({1'b0, d} <= (s8 + 8'd1))) begin
          res = DUTY_STEPS[i];
          hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Hysteresis ladder on the hotter temperature; NO_DUTY when no target.
  function automatic logic [7:0] ladder(input logic [7:0] temp, input logic [6:0] duty);
    logic [7:0] res;
    if (temp >= T_UP_65 && duty < D_65) res = {1'b0, D_65};
    else if (temp >= T_UP_40 && duty < D_40) res = {1'b0, D_40};
    else if (temp >= T_UP_30 && duty < D_30) res = {1'b0, D_30};
    else if (temp >= T_UP_17 && duty < D_17) res = {1'b0, D_17};
    else if (temp <= T_OFF) res = 8'd0;
    else if (temp <= T_DOWN_17 && duty >= D_17) res = {1'b0, D_17};
    else if (temp <= T_DOWN_30 && duty >= D_30) res = {1'b0, D_30};
    else if (temp <= T_DOWN_40 && duty >= D_40) res = {1'b0, D_40};
    else if (temp <= T_DOWN_65 && duty >= D_65) res = {1'b0, D_65};
    else res = NO_DUTY;
    return res;
  endfunction

endpackage

@@ hdl/fan_duty_hysteresis_controller.sv @@
// Fan duty hysteresis controller: duty/speed report, target ladder and write decision.
// Sequencing: each poll runs through the division steps, then the result is loaded into
//   the output register; the load waits while that register is still full.
// Pace: set by the bit-serial speed divider (one quotient bit per cycle over 22 bits);
//   one poll is in work at a time.
// Reset (rst_n low, synchronous): auto_enable is set, no duty counts as written,
//   the sequencer idles and the output register empties.
module fan_duty_hysteresis_controller (
  input  logic                       clk,
  input  logic                       rst_n,
  // cpu_deg[7:0], gpu_deg[15:8], duty_reg[23:16], rpm_high_byte[31:24],
  // rpm_low_byte[39:32]
  input  logic [fdh_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // measured_duty[6:0], fan_speed[28:7], target_duty[35:29], write_value[43:36],
  // zero fill [47:44]
  output logic [fdh_pkg::OUT_W-1:0]  out_tdata,
  // target_valid[0], write_strobe[1]
  output logic [fdh_pkg::USER_W-1:0] out_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_wen,
  input  logic                       cfg_wdata
);
  import fdh_pkg::*;

  // Control state
  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                auto_en_r, auto_en_nxt;
  logic [7:0]          last_duty_r, last_duty_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Poll payload and divider shift registers
  logic [7:0]          temp_r, temp_nxt;
  logic [7:0]          raw_r, raw_nxt;
  logic [15:0]         div_r, div_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [SPEED_W-1:0]  quo_r, quo_nxt;

  // Duty decision results
  logic [6:0]          meas_r, meas_nxt;
  logic                tgt_ok_r, tgt_ok_nxt;
  logic [6:0]          tgt_r, tgt_nxt;
  logic                strobe_r, strobe_nxt;
  logic [7:0]          wval_r, wval_nxt;

  logic [OUT_W-1:0]    out_data_r, out_data_nxt;
  logic [USER_W-1:0]   out_user_r, out_user_nxt;

  // Working signals
  logic                in_xfer, out_free;
  logic [16:0]         trial;
  logic                ge;
  logic [14:0]         raw_x100, meas_sum;
  logic [6:0]          snapped, tgt_full, diff;
  logic [7:0]          ladder_out, adj;
  logic [14:0]         tgt_x255;
  logic [27:0]         wval_prod;
  logic [SPEED_W-1:0]  speed;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Restoring division step: bring the next dividend bit into the remainder.
  assign trial = {rem_r, quo_r[SPEED_W-1]};
  assign ge    = (trial >= {1'b0, div_r});

  // floor(raw*100/255): raw*100 by shifts, then the exact /255 reciprocal form.
  assign raw_x100 = ({7'd0, raw_r} << 6) + ({7'd0, raw_r} << 5) + ({7'd0, raw_r} << 2);
  assign meas_sum = raw_x100 + 15'd1 + (raw_x100 >> 8);

  // Target and half-step adjustment, taken from the registered measured duty.
  assign snapped    = snap_duty(meas_r);
  assign ladder_out = ladder(temp_r, snapped);
  assign diff       = ladder_out[6:0] - meas_r;
  assign adj        = {1'b0, snapped} + {2'b0, diff[6:1]};

  always_comb begin
    tgt_full = ladder_out[6:0];
    if ((ladder_out != NO_DUTY) && (ladder_out[6:0] > meas_r)) begin
      if ({2'b0, ladder_out[6:0]} > ({1'b0, adj} + 9'd2)) begin
        tgt_full = adj[6:0];
      end
    end
  end

  // floor(t*255/100): t*255 by shift and subtract, then the /100 reciprocal.
  assign tgt_x255  = ({8'd0, tgt_r} << 8) - {8'd0, tgt_r};
  assign wval_prod = {13'd0, tgt_x255} * {15'd0, RECIP_100};

  // Zero tach count reports zero speed.
  assign speed = (div_r == 16'd0) ? '0 : quo_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    auto_en_nxt   = auto_en_r;
    last_duty_nxt = last_duty_r;
    out_valid_nxt = out_valid_r;
    temp_nxt      = temp_r;
    raw_nxt       = raw_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    meas_nxt      = meas_r;
    tgt_ok_nxt    = tgt_ok_r;
    tgt_nxt       = tgt_r;
    strobe_nxt    = strobe_r;
    wval_nxt      = wval_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (cfg_wen) begin
      auto_en_nxt = cfg_wdata;
    end

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          temp_nxt  = (in_tdata[7:0] > in_tdata[15:8]) ? in_tdata[7:0] : in_tdata[15:8];
          raw_nxt   = in_tdata[23:16];
          div_nxt   = {in_tdata[31:24], in_tdata[39:32]};
          rem_nxt   = '0;
          quo_nxt   = SPEED_NUM;
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        // Advance the divider one quotient bit.
        rem_nxt = ge ? 16'(trial - {1'b0, div_r}) : trial[15:0];
        quo_nxt = {quo_r[SPEED_W-2:0], ge};

        case (step_r)
          STEP_MEAS: begin
            meas_nxt = meas_sum[14:8];
          end
          STEP_TARGET: begin
            tgt_ok_nxt = (ladder_out != NO_DUTY);
            tgt_nxt    = (ladder_out != NO_DUTY) ? tgt_full : 7'd0;
          end
          STEP_WRITE: begin
            strobe_nxt = 1'b0;
            wval_nxt   = '0;
            if (tgt_ok_r && auto_en_r &&
                (({1'b0, tgt_r} != last_duty_r) || (tgt_r == 7'd0 && meas_r != 7'd0))) begin
              strobe_nxt    = 1'b1;
              wval_nxt      = wval_prod[26:19];
              last_duty_nxt = {1'b0, tgt_r};
            end
          end
          default: begin
          end
        endcase

        step_nxt = step_r + 5'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {4'd0, wval_r, tgt_r, speed, meas_r};
          out_user_nxt  = {strobe_r, tgt_ok_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      auto_en_r   <= 1'b1;
      last_duty_r <= NO_DUTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      auto_en_r   <= auto_en_nxt;
      last_duty_r <= last_duty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    temp_r     <= temp_nxt;
    raw_r      <= raw_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    meas_r     <= meas_nxt;
    tgt_ok_r   <= tgt_ok_nxt;
    tgt_r      <= tgt_nxt;
    strobe_r   <= strobe_nxt;
    wval_r     <= wval_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

`ifndef SYNTH
  // A write request only comes with a valid target.
  a_strobe_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("write strobe without a target");

  // Without a write request the write value is zero.
  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[43:36] == 8'd0))
    else $error("write value set without a strobe");

  // Percent fields stay within range.
  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[6:0] <= 7'd100) && (out_tdata[35:29] <= 7'd100)))
    else $error("percent field out of range");

  // The written-duty record only changes together with a strobe decision.
  a_last_duty_update: assert property (@(posedge clk) disable iff (!rst_n)
    (last_duty_r != $past(last_duty_r) && $past(rst_n)) |-> strobe_r)
    else $error("last written duty changed without a strobe");
`endif

endmodule

@@ sim/fan_duty_hysteresis_controller_tb.sv @@
// Self-checking testbench for the fan duty hysteresis controller: directed table plus random polls.
`timescale 1ns / 100ps

module fan_duty_hysteresis_controller_tb;

  // Settling wait for the block to answer after a transfer, with some margin on top.
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam logic [7:0]  NONE_WRITTEN  = 8'hFF;
  localparam int unsigned DUTY_STOPS [7] = '{0, 16, 30, 40, 65, 90, 100};

  // One poll as the block sees it.
  typedef struct packed {
    logic [7:0] cpu;
    logic [7:0] gpu;
    logic [7:0] duty_reg;
    logic [7:0] tach_hi;
    logic [7:0] tach_lo;
  } poll_t;

  // One report: tdata fields plus the two tuser flags.
  typedef struct packed {
    logic [6:0]  measured;
    logic [21:0] speed;
    logic        tgt_valid;
    logic [6:0]  tgt_duty;
    logic        wr_strobe;
    logic [7:0]  wr_value;
  } fan_report_t;

  // Directed row: auto_enable setting, poll, and a typed report where it is obvious.
  typedef struct packed {
    logic        auto_en;
    poll_t       poll;
    logic        typed;
    fan_report_t report;
  } dir_row_t;

  localparam int DIR_N = 23;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // Fresh from reset, everything cold and stopped: first write of zero duty.
    '{1'b1, '{8'd30, 8'd20, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{7'd0, 22'd0, 1'b1, 7'd0, 1'b1, 8'd0}},
    // Same again: zero already written and fan at zero, so no write.
    '{1'b1, '{8'd30, 8'd20, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{7'd0, 22'd0, 1'b1, 7'd0, 1'b0, 8'd0}},
    // Full duty, hottest reading, count of one: no ladder rung fits.
    '{1'b1, '{8'd255, 8'd0, 8'd255, 8'd0, 8'd1}, 1'b1,
      '{7'd100, 22'd2156220, 1'b0, 7'd0, 1'b0, 8'd0}},
    // Largest count; cold with the fan running forces a zero write.
    '{1'b1, '{8'd0, 8'd0, 8'd255, 8'hFF, 8'hFF}, 1'b1,
      '{7'd100, 22'd32, 1'b1, 7'd0, 1'b1, 8'd0}},
    // Hot GPU from standstill: half-step toward the top rung.
    '{1'b1, '{8'd40, 8'd85, 8'd0, 8'h01, 8'h00}, 1'b0, '0},
    '{1'b1, '{8'd85, 8'd10, 8'd166, 8'h80, 8'h00}, 1'b0, '0},
    // Near-full duty snaps up to full.
    '{1'b1, '{8'd86, 8'd0, 8'd253, 8'h00, 8'hFF}, 1'b0, '0},
    // One percent does not snap to the zero step.
    '{1'b1, '{8'd75, 8'd74, 8'd3, 8'h00, 8'h02}, 1'b0, '0},
    '{1'b1, '{8'd74, 8'd0, 8'd39, 8'h12, 8'h34}, 1'b0, '0},
    '{1'b1, '{8'd65, 8'd0, 8'd44, 8'h00, 8'h10}, 1'b0, '0},
    // Rising by more than two over the half step, then by exactly two.
    '{1'b1, '{8'd64, 8'd0, 8'd31, 8'h07, 8'hD0}, 1'b0, '0},
    '{1'b1, '{8'd55, 8'd0, 8'd34, 8'h07, 8'hD1}, 1'b0, '0},
    '{1'b1, '{8'd54, 8'd0, 8'd74, 8'h55, 8'hAA}, 1'b0, '0},
    // Off threshold with the fan spinning: write zero.
    '{1'b1, '{8'd50, 8'd50, 8'd80, 8'hAA, 8'h55}, 1'b0, '0},
    '{1'b1, '{8'd51, 8'd0, 8'd100, 8'h00, 8'h80}, 1'b0, '0},
    '{1'b1, '{8'd61, 8'd0, 8'd105, 8'h01, 8'h01}, 1'b0, '0},
    '{1'b1, '{8'd70, 8'd71, 8'd164, 8'h10, 8'h00}, 1'b0, '0},
    '{1'b1, '{8'd80, 8'd0, 8'd169, 8'h00, 8'h7F}, 1'b0, '0},
    '{1'b1, '{8'd81, 8'd0, 8'd227, 8'h3F, 8'hFF}, 1'b0, '0},
    // Same target as last written: hold, no write.
    '{1'b1, '{8'd81, 8'd0, 8'd233, 8'hFE, 8'h01}, 1'b0, '0},
    '{1'b1, '{8'd60, 8'd0, 8'd42, 8'h00, 8'h20}, 1'b0, '0},
    // Auto disabled: target still reported, never a write.
    '{1'b0, '{8'd90, 8'd0, 8'd0, 8'h12, 8'h34}, 1'b0, '0},
    '{1'b0, '{8'd20, 8'd0, 8'd255, 8'hFF, 8'hFE}, 1'b1,
      '{7'd100, 22'd32, 1'b1, 7'd0, 1'b0, 8'd0}}
  };

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic [fdh_pkg::IN_W-1:0]   in_tdata   = '0;
  logic                       in_tvalid  = 1'b0;
  logic                       in_tready;
  logic [fdh_pkg::OUT_W-1:0]  out_tdata;
  logic [fdh_pkg::USER_W-1:0] out_tuser;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic                       cfg_wen    = 1'b0;
  logic                       cfg_wdata  = 1'b0;

  // Predictor state: mirror of the auto_enable register and the last duty written.
  logic        auto_on      = 1'b1;
  logic [7:0]  duty_written = NONE_WRITTEN;
  fan_report_t reports_due [$];
  int          mismatch_count = 0;

  // Idle odds, one in N: a source transfer is preceded by a gap, or the sink starts a stall; 0 turns idling off.
  int unsigned src_gap_odds   = 4;
  int unsigned sink_stall_odds = 4;
  int unsigned sink_stall_left = 0;
  int          heat = 45;

  fan_duty_hysteresis_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Compute the report for one accepted poll and advance the written-duty state.
  function automatic fan_report_t predict_poll(input poll_t p);
    fan_report_t r;
    int unsigned count, raw, measured, hotter, snapped, target, half;
    logic        has_target;
    count    = {p.tach_hi, p.tach_lo};
    raw      = p.duty_reg;
    measured = raw * 100 / 255;
    hotter   = (p.cpu > p.gpu) ? p.cpu : p.gpu;

    // Snap to the first stop within one point; the zero stop wants an exact zero.
    snapped = measured;
    if (measured == 0) begin
      snapped = 0;
    end else begin
      for (int i = 6; i >= 1; i--) begin
        if (measured + 1 >= DUTY_STOPS[i] && measured <= DUTY_STOPS[i] + 1)
          snapped = DUTY_STOPS[i];
      end
    end

    // Hysteresis ladder: rising rungs first, then the falling ones.
    has_target = 1'b1;
    target     = 0;
    if (hotter >= 85 && snapped < 65) target = 65;
    else if (hotter >= 75 && snapped < 40) target = 40;
    else if (hotter >= 65 && snapped < 30) target = 30;
    else if (hotter >= 55 && snapped < 17) target = 17;
    else if (hotter <= 50) target = 0;
    else if (hotter <= 60 && snapped >= 17) target = 17;
    else if (hotter <= 70 && snapped >= 30) target = 30;
    else if (hotter <= 80 && snapped >= 40) target = 40;
    else if (hotter <= 85 && snapped >= 65) target = 65;
    else has_target = 1'b0;

    // Move only half-way when a rising target is well above the current duty.
    if (has_target && target > measured) begin
      half = snapped + (target - measured) / 2;
      if (target > half + 2) target = half;
    end

    r           = '0;
    r.measured  = measured[6:0];
    r.speed     = (count == 0) ? 22'd0 : 22'(2156220 / count);
    r.tgt_valid = has_target;
    r.tgt_duty  = has_target ? target[6:0] : 7'd0;
    if (has_target && auto_on &&
        (target != duty_written || (target == 0 && measured != 0))) begin
      r.wr_strobe  = 1'b1;
      r.wr_value   = 8'(target * 255 / 100);
      duty_written = target[7:0];
    end
    return r;
  endfunction

  // Present one poll, hold it until the transfer, then book its report.
  task automatic send_poll(input poll_t p);
    if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tdata  <= {p.tach_lo, p.tach_hi, p.duty_reg, p.gpu, p.cpu};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    reports_due.push_back(predict_poll(p));
  endtask

  // Write auto_enable once the block has drained.
  task automatic set_auto(input logic en);
    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    auto_on   = en;
  endtask

  // Mostly a drifting temperature with the fan duty fed back from the last write,
  // some polls near the duty stops, and some plain noise.
  task automatic run_random(input int n);
    poll_t       p;
    int unsigned mode, hot, pct_pick;
    int          pct;
    repeat (n) begin
      mode = $urandom_range(0, 99);
      heat = heat + int'($urandom_range(0, 12)) - 6;
      if (heat < 30) heat = 30;
      if (heat > 105) heat = 105;
      hot = (mode < 85) ? heat : $urandom_range(0, 255);
      if ($urandom_range(0, 1)) begin
        p.cpu = hot[7:0];
        p.gpu = 8'($urandom_range(0, hot));
      end else begin
        p.gpu = hot[7:0];
        p.cpu = 8'($urandom_range(0, hot));
      end

      if (mode < 60 && duty_written != NONE_WRITTEN) begin
        p.duty_reg = 8'(duty_written * 255 / 100);
      end else if (mode < 85) begin
        pct_pick = $urandom_range(0, 6);
        pct = int'(DUTY_STOPS[pct_pick]) + int'($urandom_range(0, 4)) - 2;
        if (pct < 0) pct = 0;
        if (pct > 100) pct = 100;
        p.duty_reg = 8'((pct * 255 + 99) / 100);
      end else begin
        p.duty_reg = 8'($urandom_range(0, 255));
      end

      case ($urandom_range(0, 9))
        0: {p.tach_hi, p.tach_lo} = 16'd0;
        1: {p.tach_hi, p.tach_lo} = 16'($urandom_range(1, 3));
        2: {p.tach_hi, p.tach_lo} = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        default: {p.tach_hi, p.tach_lo} = 16'($urandom_range(0, 16'hFFFF));
      endcase
      send_poll(p);
    end
  endtask

  // Result side backpressure: random stall bursts.
  always @(posedge clk) begin
    if (sink_stall_left != 0) begin
      out_tready      <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
      out_tready      <= 1'b0;
      sink_stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every report transfer against the oldest outstanding prediction.
  always @(posedge clk) begin
    fan_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.measured  = out_tdata[6:0];
      got.speed     = out_tdata[28:7];
      got.tgt_duty  = out_tdata[35:29];
      got.wr_value  = out_tdata[43:36];
      got.tgt_valid = out_tuser[0];
      got.wr_strobe = out_tuser[1];
      if (reports_due.size() == 0) begin
        $display("%0t: report with none outstanding: duty=%0d speed=%0d", $time,
                 got.measured, got.speed);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        if (got !== want) begin
          $display({"%0t: report mismatch exp duty=%0d speed=%0d tv=%0d tgt=%0d ws=%0d ",
                    "wv=%0d got duty=%0d speed=%0d tv=%0d tgt=%0d ws=%0d wv=%0d"},
                   $time, want.measured, want.speed, want.tgt_valid, want.tgt_duty,
                   want.wr_strobe, want.wr_value, got.measured, got.speed,
                   got.tgt_valid, got.tgt_duty, got.wr_strobe, got.wr_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_auto(1'b1);

    // Directed table; typed rows override the prediction, state still advances.
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].auto_en != auto_on) set_auto(DIR_TAB[i].auto_en);
      send_poll(DIR_TAB[i].poll);
      if (DIR_TAB[i].typed) reports_due[reports_due.size() - 1] = DIR_TAB[i].report;
    end

    set_auto(1'b1);
    src_gap_odds = 3; sink_stall_odds = 3;
    run_random(100);

    set_auto(1'b0);
    run_random(120);

    // A stretch with a steady source, then one with source gaps again.
    set_auto(1'b1);
    src_gap_odds = 0; sink_stall_odds = 2;
    run_random(150);
    src_gap_odds = 2; sink_stall_odds = 5;
    run_random(180);

    set_auto(1'b0);
    run_random(50);

    // Last stretch: no idling on either side.
    set_auto(1'b1);
    src_gap_odds = 0; sink_stall_odds = 0;
    run_random(200);

    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fan_duty_hysteresis_controller verification clean");
    end else begin
      $display("fan_duty_hysteresis_controller verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3_000_000;
    $display("fan_duty_hysteresis_controller verification failed");
    $finish;
  end

endmodule

@@ fan_duty_hysteresis_controller.f @@
hdl/fdh_pkg.sv
hdl/fan_duty_hysteresis_controller.sv
sim/fan_duty_hysteresis_controller_tb.sv
